// File: design/sfbi_pkg.sv
package sfbi_pkg;

    // store depths and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_AW     = $clog2(MAX_WIDTH);
    localparam int ROW_AW     = $clog2(MAX_HEIGHT);

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 10;
    localparam int SAMPLE_W = 8;
    localparam int SIZE_W   = 11;

    // interpolation datapath
    localparam int PROD_W   = SAMPLE_W + SIZE_W;
    localparam int QUOT_W   = SAMPLE_W;
    localparam int DCNT_W   = $clog2(QUOT_W);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(QUOT_W - 1);

    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] MIN_SZ   = SIZE_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_LEFT   = 3'd0,
        CMD_WR_RIGHT  = 3'd1,
        CMD_WR_TOP    = 3'd2,
        CMD_WR_BOTTOM = 3'd3,
        CMD_COMPUTE   = 3'd4
    } cmd_t;

    typedef enum logic {
        REG_RECT_WIDTH  = 1'b0,
        REG_RECT_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV
    } state_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

endpackage

// File: design/sfbi_ram.sv
module sfbi_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sfbi_div.sv
module sfbi_div
    import sfbi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output div_res_t          res
);

    // restoring division, one quotient bit per cycle, msb first
    // caller guarantees dividend < divisor * 2**QUOT_W

    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] rem_next;
    logic [PROD_W-1:0] dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic              ge;

    assign ge       = (rem_reg >= dsh_reg);
    assign rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= PROD_W'({divisor, {(QUOT_W-1){1'b0}}});
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

// File: design/spot_fill_boundary_interpolator.sv
// Boundary interpolation fill for one 8-bit channel. Write requests (cmd 0..3) load the
// left/right sample of a rectangle row or the top/bottom sample of a rectangle column;
// a compute request (cmd 4) returns one pixel at (row, col) as the average of the
// horizontal and vertical linear interpolations, each floored exactly. A request is
// taken when start is high and busy is low. Results appear on pixel/out_of_range for
// exactly one cycle with done high; the receiver cannot stall, so it must take every
// strobe. Writes and out-of-range computes keep busy high only for the S_READ state (the
// read-modify-write of the boundary memory). An in-range compute keeps busy high through
// the memory read, the multiply, the bit-serial restoring dividers and the result
// cycle; done is high in the first cycle with busy low again. Boundary
// entries read before they were written return unspecified data. rect_width/rect_height
// must only be written while the block is idle; 0 acts as 1 and values above 1024 as 1024.
module spot_fill_boundary_interpolator
    import sfbi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [SIZE_W-1:0]   wr_data,
    // request
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [POS_W-1:0]    row,
    input  logic [POS_W-1:0]    col,
    input  logic [SAMPLE_W-1:0] sample,
    // result
    output logic                done,
    output logic [SAMPLE_W-1:0] pixel,
    output logic                out_of_range
);

    // configuration registers
    logic [SIZE_W-1:0] rect_width_reg;
    logic [SIZE_W-1:0] rect_height_reg;
    logic [SIZE_W-1:0] eff_w;
    logic [SIZE_W-1:0] eff_h;

    // fsm
    state_t state_reg;
    state_t state_next;

    // latched request
    logic [CMD_W-1:0]    cmd_reg;
    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    col_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // boundary memories: {right, left} by row and {bottom, top} by col
    logic                  lr_we;
    logic [2*SAMPLE_W-1:0] lr_wdata;
    logic [2*SAMPLE_W-1:0] lr_rdata;
    logic                  tb_we;
    logic [2*SAMPLE_W-1:0] tb_wdata;
    logic [2*SAMPLE_W-1:0] tb_rdata;
    logic [SAMPLE_W-1:0]   left_s;
    logic [SAMPLE_W-1:0]   right_s;
    logic [SAMPLE_W-1:0]   top_s;
    logic [SAMPLE_W-1:0]   bottom_s;

    // interpolation datapath
    logic [PROD_W-1:0] pa_reg;
    logic [PROD_W-1:0] pb_reg;
    logic [PROD_W-1:0] pc_reg;
    logic [PROD_W-1:0] pd_reg;
    logic [SIZE_W-1:0] col_x;
    logic [SIZE_W-1:0] row_x;
    logic              oor;
    div_res_t          h_res;
    div_res_t          v_res;
    logic [SAMPLE_W:0] avg_sum;

    // control decoded per state
    logic is_compute;
    logic row_in_store;
    logic col_in_store;
    logic load_prod;
    logic div_start;
    logic emit_oor;
    logic emit_pix;

    // result registers
    logic                done_reg;
    logic [SAMPLE_W-1:0] pixel_reg;
    logic                oor_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_width_reg  <= MIN_SZ;
            rect_height_reg <= MIN_SZ;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_RECT_WIDTH:  rect_width_reg  <= wr_data;
                REG_RECT_HEIGHT: rect_height_reg <= wr_data;
                default:         ;
            endcase
        end
    end

    // saturate sizes to 1..max
    assign eff_w = (rect_width_reg == '0) ? MIN_SZ :
                   (rect_width_reg > MAX_W_SZ) ? MAX_W_SZ : rect_width_reg;
    assign eff_h = (rect_height_reg == '0) ? MIN_SZ :
                   (rect_height_reg > MAX_H_SZ) ? MAX_H_SZ : rect_height_reg;

    assign busy = (state_reg != S_IDLE);

    // ---------------- request capture ----------------
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg    <= cmd;
            row_reg    <= row;
            col_reg    <= col;
            sample_reg <= sample;
        end
    end

    // ---------------- boundary memories ----------------
    // read address follows the ports every cycle, so the read data in S_READ
    // belongs to the request taken on the edge before
    sfbi_ram #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (2*SAMPLE_W)
    ) u_lr_ram (
        .clk   (clk),
        .we    (lr_we),
        .waddr (row_reg[ROW_AW-1:0]),
        .wdata (lr_wdata),
        .raddr (row[ROW_AW-1:0]),
        .rdata (lr_rdata)
    );

    sfbi_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2*SAMPLE_W)
    ) u_tb_ram (
        .clk   (clk),
        .we    (tb_we),
        .waddr (col_reg[COL_AW-1:0]),
        .wdata (tb_wdata),
        .raddr (col[COL_AW-1:0]),
        .rdata (tb_rdata)
    );

    assign left_s   = lr_rdata[SAMPLE_W-1:0];
    assign right_s  = lr_rdata[2*SAMPLE_W-1:SAMPLE_W];
    assign top_s    = tb_rdata[SAMPLE_W-1:0];
    assign bottom_s = tb_rdata[2*SAMPLE_W-1:SAMPLE_W];

    // merge the new sample into the half it belongs to, keep the other half
    assign lr_wdata = (cmd_reg == CMD_WR_LEFT) ? {right_s, sample_reg} : {sample_reg, left_s};
    assign tb_wdata = (cmd_reg == CMD_WR_TOP)  ? {bottom_s, sample_reg} : {sample_reg, top_s};

    // writes past the store depth are dropped
    assign row_in_store = ({1'b0, row_reg} < MAX_H_SZ);
    assign col_in_store = ({1'b0, col_reg} < MAX_W_SZ);

    // ---------------- range check ----------------
    assign col_x = {1'b0, col_reg};
    assign row_x = {1'b0, row_reg};
    assign oor   = (row_x >= eff_h) || (col_x >= eff_w);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (is_compute && !oor)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (h_res.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- state outputs ----------------
    assign is_compute = (cmd_reg == CMD_COMPUTE);

    always_comb
    begin
        lr_we     = 1'b0;
        tb_we     = 1'b0;
        load_prod = 1'b0;
        div_start = 1'b0;
        emit_oor  = 1'b0;
        emit_pix  = 1'b0;
        case (state_reg)
            S_READ:
            begin
                lr_we     = ((cmd_reg == CMD_WR_LEFT) || (cmd_reg == CMD_WR_RIGHT))
                            && row_in_store;
                tb_we     = ((cmd_reg == CMD_WR_TOP) || (cmd_reg == CMD_WR_BOTTOM))
                            && col_in_store;
                load_prod = is_compute && !oor;
                emit_oor  = is_compute && oor;
            end
            S_MUL:
            begin
                div_start = 1'b1;
            end
            S_DIV:
            begin
                emit_pix = h_res.done;
            end
            default:
            begin
                lr_we = 1'b0;
            end
        endcase
    end

    // ---------------- multiply stage ----------------
    // weights: left*(w-col) + right*col, top*(h-row) + bottom*row
    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            pa_reg <= PROD_W'(left_s * (eff_w - col_x));
            pb_reg <= PROD_W'(right_s * col_x);
            pc_reg <= PROD_W'(top_s * (eff_h - row_x));
            pd_reg <= PROD_W'(bottom_s * row_x);
        end
    end

    // ---------------- dividers ----------------
    sfbi_div u_h_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pa_reg + pb_reg),
        .divisor  (eff_w),
        .res      (h_res)
    );

    sfbi_div u_v_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pc_reg + pd_reg),
        .divisor  (eff_h),
        .res      (v_res)
    );

    // both parts are at most 255, so the average never needs the clamp
    assign avg_sum = {1'b0, h_res.quot} + {1'b0, v_res.quot};

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit_oor || emit_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_oor)
        begin
            pixel_reg <= '0;
            oor_reg   <= 1'b1;
        end
        else if (emit_pix)
        begin
            pixel_reg <= avg_sum[SAMPLE_W:1];
            oor_reg   <= 1'b0;
        end
    end

    assign done         = done_reg;
    assign pixel        = pixel_reg;
    assign out_of_range = oor_reg;

`ifndef NO_ASSERTIONS
    // the two dividers run in lock step
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        h_res.done == v_res.done)
        else $error("divider done strobes diverged");

    // a result only follows the read cycle or the last divide cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_READ || $past(state_reg) == S_DIV))
        else $error("result strobe without a compute in flight");

    // an out-of-range result carries pixel zero
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> pixel == '0)
        else $error("out-of-range result with nonzero pixel");

    // write requests produce no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd != CMD_COMPUTE |-> ##2 !done)
        else $error("result strobe after a non-compute request");
`endif

endmodule
